### hw/rtl/assert_macros.svh
// Assertion macros used by the RTL sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock outside reset.
`define PFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be seen outside reset.
`define PFD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### hw/rtl/pfd_pkg.sv
// Types, constants, microcode table and helpers of the PID controller.
package pfd_pkg;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int PROD_W    = 2 * (DW + 1);
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;

    localparam logic [16:0] ALPHA_ONE = 17'd65536;

    localparam logic [2:0] REG_KP     = 3'd0;
    localparam logic [2:0] REG_KI     = 3'd1;
    localparam logic [2:0] REG_KD     = 3'd2;
    localparam logic [2:0] REG_PERIOD = 3'd3;
    localparam logic [2:0] REG_RATE   = 3'd4;
    localparam logic [2:0] REG_ALPHA  = 3'd5;
    localparam logic [2:0] REG_MIN    = 3'd6;
    localparam logic [2:0] REG_MAX    = 3'd7;

    localparam logic [1:0] CS_NONE = 2'd0;
    localparam logic [1:0] CS_HIGH = 2'd1;
    localparam logic [1:0] CS_LOW  = 2'd2;

    typedef enum logic [1:0] {
        ALU_NOP,
        ALU_ERR,
        ALU_ESUM,
        ALU_FINAL
    } t_alu;

    // multiplier operand pair; also tags the result for write-back
    typedef enum logic [2:0] {
        M_NONE,
        M_KP_E,
        M_RATE_DM,
        M_AC_DFILT,
        M_KD_DRAW,
        M_KI_TS,
        M_A_KDD,
        M_KTS_ESUM
    } t_msel;

    typedef logic [STEP_W-1:0] t_step;

    typedef struct packed {
        t_alu  alu;
        t_msel msel;
        logic  jz_ki;
        t_step target;
        logic  last;
    } t_uop;

    localparam t_uop UOP_IDLE = '{alu: ALU_NOP, msel: M_NONE, jz_ki: 1'b0,
                                  target: '0, last: 1'b0};

    localparam t_step UC_LAST = t_step'(9);

    function automatic t_uop ucode(input t_step s);
        t_uop u;
        u = UOP_IDLE;
        case (s)
            t_step'(0): u.alu = ALU_ERR;
            t_step'(1): begin
                u.alu  = ALU_ESUM;
                u.msel = M_KP_E;
            end
            t_step'(2): u.msel = M_RATE_DM;
            t_step'(3): u.msel = M_AC_DFILT;
            t_step'(4): u.msel = M_KD_DRAW;
            t_step'(5): u.msel = M_KI_TS;
            t_step'(6): begin
                u.msel   = M_A_KDD;
                u.jz_ki  = 1'b1;
                u.target = t_step'(8);
            end
            t_step'(7): u.msel = M_KTS_ESUM;
            t_step'(8): u.msel = M_NONE;
            t_step'(9): begin
                u.alu  = ALU_FINAL;
                u.last = 1'b1;
            end
            default: u = UOP_IDLE;
        endcase
        return u;
    endfunction

    function automatic logic signed [DW-1:0] sat32(input logic signed [DW+1:0] v);
        logic signed [DW+1:0] hi;
        logic signed [DW+1:0] lo;
        hi = {3'b000, {(DW-1){1'b1}}};
        lo = {3'b111, {(DW-1){1'b0}}};
        if (v > hi) begin
            return hi[DW-1:0];
        end else if (v < lo) begin
            return lo[DW-1:0];
        end
        return v[DW-1:0];
    endfunction

endpackage

### hw/rtl/pfd_in_if.sv
// Input channel: update/init word with handshake.
interface pfd_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic signed [31:0] setpoint;
    logic signed [31:0] measured;

    modport source(output valid, cmd, setpoint, measured, input ready);
    modport sink(input valid, cmd, setpoint, measured, output ready);
endinterface

### hw/rtl/pfd_out_if.sv
// Output channel: drive word with handshake.
interface pfd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] drive;
    logic [1:0]         clamp_state;
    logic               integ_frozen;

    modport source(output valid, drive, clamp_state, integ_frozen, input ready);
    modport sink(input valid, drive, clamp_state, integ_frozen, output ready);
endinterface

### hw/rtl/pid_filtered_deriv_antiwindup.sv
// Top level: PID controller with filtered derivative and anti-windup.
// channel  dir  words
// i_in     in   cmd, setpoint, measured
// o_out    out  drive, clamp_state, integ_frozen
// i_cfg    in   we, idx, data (register write, no read-back)
// An update word runs a 10-step microprogram (9 steps when ki is zero) on one
// shared multiplier; ready returns in the cycle after the last step, so a new
// word is not accepted until the update is done. An init word is taken while idle.
// The last step waits while the output register is full and not taken.
// Reset is synchronous, loads the register defaults and clears the integrator, filter, history and output valid.
module pid_filtered_deriv_antiwindup (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    pfd_in_if.sink                            i_in,
    pfd_out_if.source                         o_out,
    input  logic                              i_cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pfd_pkg::DW-1:0]            i_cfg_data
);

    localparam int DW = pfd_pkg::DW;

    logic signed [DW-1:0] r_kp, r_ki, r_kd, r_min, r_max;
    logic [DW-2:0]        r_period, r_rate;
    logic [16:0]          r_alpha;

    logic signed [DW-1:0] r_integ, r_old_integ, r_prev_error, r_prev_meas, r_dfilt;
    logic signed [DW-1:0] r_sp, r_meas, r_e, r_p, r_draw, r_t, r_kdd, r_kts;
    logic signed [DW:0]   r_dm, r_esum;

    logic                 r_ovld;
    logic signed [DW-1:0] r_drive;
    logic [1:0]           r_cs;
    logic                 r_frz;

    logic                 w_acc, w_busy, w_hold, w_ki_zero;
    pfd_pkg::t_uop        w_uop;
    pfd_pkg::t_msel       w_tag;
    logic signed [DW-1:0] w_res;
    logic signed [DW:0]   w_a, w_b;
    logic [16:0]          w_alpha;
    logic signed [DW:0]   w_diff;
    logic signed [DW+1:0] w_u;
    logic                 w_hi, w_lo, w_push, w_frz;

    assign i_in.ready = !w_busy;
    assign w_acc      = i_in.valid && !w_busy;
    assign w_hold     = r_ovld && !o_out.ready;
    assign w_ki_zero  = (r_ki == '0);
    assign w_alpha    = (r_alpha > pfd_pkg::ALPHA_ONE) ? pfd_pkg::ALPHA_ONE : r_alpha;

    pfd_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_acc && !i_in.cmd),
        .i_ki_zero (w_ki_zero),
        .i_hold    (w_hold),
        .o_uop     (w_uop),
        .o_busy    (w_busy)
    );

    always_comb begin
        w_a = '0;
        w_b = '0;
        case (w_uop.msel)
            pfd_pkg::M_KP_E: begin
                w_a = {r_kp[DW-1], r_kp};
                w_b = {r_e[DW-1], r_e};
            end
            pfd_pkg::M_RATE_DM: begin
                w_a = {2'b00, r_rate};
                w_b = r_dm;
            end
            pfd_pkg::M_AC_DFILT: begin
                w_a = (DW+1)'(pfd_pkg::ALPHA_ONE - w_alpha);
                w_b = {r_dfilt[DW-1], r_dfilt};
            end
            pfd_pkg::M_KD_DRAW: begin
                w_a = {r_kd[DW-1], r_kd};
                w_b = {r_draw[DW-1], r_draw};
            end
            pfd_pkg::M_KI_TS: begin
                w_a = {r_ki[DW-1], r_ki};
                w_b = {2'b00, r_period};
            end
            pfd_pkg::M_A_KDD: begin
                w_a = (DW+1)'(w_alpha);
                w_b = {r_kdd[DW-1], r_kdd};
            end
            pfd_pkg::M_KTS_ESUM: begin
                w_a = {r_kts[DW-1], r_kts};
                w_b = r_esum;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    pfd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_uop.msel),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_tag   (w_tag),
        .o_res   (w_res)
    );

    assign w_diff = {r_sp[DW-1], r_sp} - {r_meas[DW-1], r_meas};

    always_comb begin
        w_u = {{2{r_p[DW-1]}}, r_p} + {{2{r_integ[DW-1]}}, r_integ}
            + {{2{r_dfilt[DW-1]}}, r_dfilt};
        w_hi   = w_u > $signed({{2{r_max[DW-1]}}, r_max});
        w_lo   = w_u < $signed({{2{r_min[DW-1]}}, r_min});
        w_push = (r_ki[DW-1] == r_e[DW-1]);
        w_frz  = !w_ki_zero && (r_e != '0) && ((w_hi && w_push) || (w_lo && !w_push));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp         <= DW'(65536);
            r_ki         <= '0;
            r_kd         <= '0;
            r_period     <= (DW-1)'(65536);
            r_rate       <= (DW-1)'(65536);
            r_alpha      <= 17'd5958;
            r_min        <= '0;
            r_max        <= DW'(65536);
            r_integ      <= '0;
            r_prev_error <= '0;
            r_prev_meas  <= '0;
            r_dfilt      <= '0;
            r_ovld       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pfd_pkg::REG_KP:     r_kp     <= i_cfg_data;
                    pfd_pkg::REG_KI:     r_ki     <= i_cfg_data;
                    pfd_pkg::REG_KD:     r_kd     <= i_cfg_data;
                    pfd_pkg::REG_PERIOD: r_period <= i_cfg_data[DW-2:0];
                    pfd_pkg::REG_RATE:   r_rate   <= i_cfg_data[DW-2:0];
                    pfd_pkg::REG_ALPHA:  r_alpha  <= i_cfg_data[16:0];
                    pfd_pkg::REG_MIN:    r_min    <= i_cfg_data;
                    pfd_pkg::REG_MAX:    r_max    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_acc && i_in.cmd) begin
                r_integ      <= '0;
                r_prev_error <= '0;
                r_dfilt      <= '0;
                r_prev_meas  <= i_in.measured;
            end

            case (w_tag)
                pfd_pkg::M_A_KDD:
                    r_dfilt <= pfd_pkg::sat32({{2{r_t[DW-1]}}, r_t}
                                              + {{2{w_res[DW-1]}}, w_res});
                pfd_pkg::M_KTS_ESUM:
                    r_integ <= pfd_pkg::sat32({{2{r_integ[DW-1]}}, r_integ}
                                              + {{2{w_res[DW-1]}}, w_res});
                default: ;
            endcase

            if (w_uop.alu == pfd_pkg::ALU_FINAL) begin
                if (w_frz) begin
                    r_integ <= r_old_integ;
                end
                r_prev_error <= r_e;
                r_prev_meas  <= r_meas;
                r_ovld       <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end
        end

        if (w_acc) begin
            r_sp   <= i_in.setpoint;
            r_meas <= i_in.measured;
        end

        case (w_uop.alu)
            pfd_pkg::ALU_ERR: begin
                r_e         <= pfd_pkg::sat32({w_diff[DW], w_diff});
                r_dm        <= {r_prev_meas[DW-1], r_prev_meas} - {r_meas[DW-1], r_meas};
                r_old_integ <= r_integ;
            end
            pfd_pkg::ALU_ESUM:
                r_esum <= {r_e[DW-1], r_e} + {r_prev_error[DW-1], r_prev_error};
            pfd_pkg::ALU_FINAL: begin
                if (w_lo) begin
                    r_drive <= r_min;
                    r_cs    <= pfd_pkg::CS_LOW;
                end else if (w_hi) begin
                    r_drive <= r_max;
                    r_cs    <= pfd_pkg::CS_HIGH;
                end else begin
                    r_drive <= w_u[DW-1:0];
                    r_cs    <= pfd_pkg::CS_NONE;
                end
                r_frz <= w_frz;
            end
            default: ;
        endcase

        case (w_tag)
            pfd_pkg::M_KP_E:     r_p    <= w_res;
            pfd_pkg::M_RATE_DM:  r_draw <= w_res;
            pfd_pkg::M_AC_DFILT: r_t    <= w_res;
            pfd_pkg::M_KD_DRAW:  r_kdd  <= w_res;
            pfd_pkg::M_KI_TS:    r_kts  <= w_res;
            default: ;
        endcase
    end

    assign o_out.valid        = r_ovld;
    assign o_out.drive        = r_drive;
    assign o_out.clamp_state  = r_cs;
    assign o_out.integ_frozen = r_frz;

endmodule

### hw/rtl/pfd_mul.sv
// Shared multiplier: product register, then round half away and saturate.
module pfd_mul (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pfd_pkg::t_msel                    i_tag,
    input  logic signed [pfd_pkg::DW:0]       i_a,
    input  logic signed [pfd_pkg::DW:0]       i_b,
    output pfd_pkg::t_msel                    o_tag,
    output logic signed [pfd_pkg::DW-1:0]     o_res
);

    logic [pfd_pkg::DW:0]         w_ma;
    logic [pfd_pkg::DW:0]         w_mb;
    logic [pfd_pkg::PROD_W-1:0]   r_mag;
    logic                         r_neg;
    pfd_pkg::t_msel               r_tag;
    logic                         w_sh17;
    logic [pfd_pkg::PROD_W:0]     w_sum;
    logic [pfd_pkg::PROD_W-pfd_pkg::FB:0] w_q;
    logic [pfd_pkg::PROD_W-pfd_pkg::FB:0] w_lim;
    logic [pfd_pkg::DW-1:0]       w_qs;

    assign w_ma = i_a[pfd_pkg::DW] ? -i_a : i_a;
    assign w_mb = i_b[pfd_pkg::DW] ? -i_b : i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= pfd_pkg::M_NONE;
        end else begin
            r_tag <= i_tag;
        end
        r_mag <= w_ma * w_mb;
        r_neg <= i_a[pfd_pkg::DW] ^ i_b[pfd_pkg::DW];
    end

    // the integrator increment carries the extra halving bit
    assign w_sh17 = (r_tag == pfd_pkg::M_KTS_ESUM);

    always_comb begin
        w_sum = {1'b0, r_mag} + (w_sh17 ? ((pfd_pkg::PROD_W+1)'(1) << pfd_pkg::FB)
                                        : ((pfd_pkg::PROD_W+1)'(1) << (pfd_pkg::FB - 1)));
        if (w_sh17) begin
            w_q = {1'b0, w_sum[pfd_pkg::PROD_W:pfd_pkg::FB+1]};
        end else begin
            w_q = w_sum[pfd_pkg::PROD_W:pfd_pkg::FB];
        end
        w_lim = (pfd_pkg::PROD_W-pfd_pkg::FB+1)'(1) << (pfd_pkg::DW - 1);
        if (!r_neg) begin
            w_lim = w_lim - 1'b1;
        end
        w_qs  = (w_q > w_lim) ? w_lim[pfd_pkg::DW-1:0] : w_q[pfd_pkg::DW-1:0];
        o_res = r_neg ? -w_qs : w_qs;
    end

    assign o_tag = r_tag;

endmodule

### hw/rtl/pfd_seq.sv
// Microcode sequencer: step counter, program table, conditional jumps.
`include "assert_macros.svh"

module pfd_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_ki_zero,
    input  logic          i_hold,
    output pfd_pkg::t_uop o_uop,
    output logic          o_busy
);

    logic                r_busy;
    pfd_pkg::t_step      r_step;
    pfd_pkg::t_uop       w_uop;

    assign w_uop = r_busy ? pfd_pkg::ucode(r_step) : pfd_pkg::UOP_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end
        end else if (w_uop.last) begin
            if (!i_hold) begin
                r_busy <= 1'b0;
            end
        end else if (w_uop.jz_ki && i_ki_zero) begin
            r_step <= w_uop.target;
        end else begin
            r_step <= r_step + 1'b1;
        end
    end

    always_comb begin
        o_uop = w_uop;
        if (w_uop.last && i_hold) begin
            o_uop.alu = pfd_pkg::ALU_NOP;
        end
    end

    assign o_busy = r_busy;

    `PFD_NEVER(a_step_range, i_clk, i_rst_n, r_busy && (r_step > pfd_pkg::UC_LAST), "step past end")
    `PFD_ASSERT(a_start, i_clk, i_rst_n, i_start && !r_busy |=> r_busy && (r_step == '0), "start lost")
    `PFD_ASSERT(a_run, i_clk, i_rst_n, r_busy && !w_uop.last |=> r_busy, "program ended early")

endmodule
